### hdl/ssd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Swept segment point distance package
// Shared widths, constants and item types of the block.
// ---------------------------------------------------------------------------
package ssd_pkg;

    localparam int FINE_BITS    = 21;
    localparam int COARSE_SHIFT = 5;
    localparam int Q8_ONE       = 256;
    localparam int DIST_BITS    = 42;
    localparam int POS_BITS     = 21;
    localparam int VEL_BITS     = 16;
    localparam int ALT_BITS     = 16;
    localparam int TGT_BITS     = 16;

    localparam int DIFFW = POS_BITS + COARSE_SHIFT + TGT_BITS;
    localparam int PW    = ((FINE_BITS > VEL_BITS) ? FINE_BITS : VEL_BITS) + 1;
    localparam int ZW    = ALT_BITS + 2;
    localparam int PRODW = PW + VEL_BITS;
    localparam int DOTW  = PRODW + 2;
    localparam int SEGW  = 2 * VEL_BITS;
    localparam int REMW  = SEGW + 1;
    localparam int QW    = 8;
    localparam int TW    = QW + 1;
    localparam int MW    = VEL_BITS + TW + 1;
    localparam int CW    = PW + 1;
    localparam int SQW   = 2 * CW;
    localparam int SUMW  = SQW + 2;
    localparam int EW    = (SUMW > DIST_BITS) ? SUMW : DIST_BITS;

    localparam logic [63:0] DIST_MAX = (64'd1 << DIST_BITS) - 64'd1;

    typedef struct packed {
        logic signed [PW-1:0]       px;
        logic signed [PW-1:0]       py;
        logic signed [ZW-1:0]       pz;
        logic signed [VEL_BITS-1:0] vx;
        logic signed [VEL_BITS-1:0] vy;
        logic signed [VEL_BITS-1:0] vz;
        logic                       zero_seg;
    } seg_item_t;

    typedef struct packed {
        seg_item_t       item;
        logic [SEGW-1:0] seg2;
        logic [REMW-1:0] rem;
        logic [QW-1:0]   quo;
        logic            bypass;
        logic [TW-1:0]   t_fix;
    } div_item_t;

    typedef struct packed {
        logic [DIST_BITS-1:0] dsq;
        logic [TW-1:0]        frac;
    } res_item_t;

endpackage

### hdl/swept_segment_point_distance_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Swept segment point distance
// Squared closest approach of a target to one step of a projectile path.
// ---------------------------------------------------------------------------
// Channel  | Handshake     | Payload
// input    | push / full   | round_x, round_y, round_alt, vel_x/y/z, target_x/y/alt
// result   | pop / empty   | dist_sq, seg_fraction
//
// One item is accepted per cycle while full is low.
// Each item passes through the eight-stage divider plus the multiply stages around it.
// Reset clears only valid flags, queue pointers and queue counts.
// When the result queue fills, the back pipeline freezes and the front queue
// absorbs up to three more items before full rises.
module swept_segment_point_distance_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [ssd_pkg::POS_BITS-1:0]        round_x,
    input  logic [ssd_pkg::POS_BITS-1:0]        round_y,
    input  logic signed [ssd_pkg::ALT_BITS-1:0] round_alt,
    input  logic signed [ssd_pkg::VEL_BITS-1:0] vel_x,
    input  logic signed [ssd_pkg::VEL_BITS-1:0] vel_y,
    input  logic signed [ssd_pkg::VEL_BITS-1:0] vel_z,
    input  logic [ssd_pkg::TGT_BITS-1:0]        target_x,
    input  logic [ssd_pkg::TGT_BITS-1:0]        target_y,
    input  logic signed [ssd_pkg::ALT_BITS-1:0] target_alt,
    output logic                                empty,
    input  logic                                pop,
    output logic [ssd_pkg::DIST_BITS-1:0]       dist_sq,
    output logic [ssd_pkg::TW-1:0]              seg_fraction
);

    logic               f_valid;
    ssd_pkg::seg_item_t f_item;
    logic               q_full;
    logic               q_empty;
    logic               q_pop;
    ssd_pkg::seg_item_t q_item;

    ssd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .round_x    (round_x),
        .round_y    (round_y),
        .round_alt  (round_alt),
        .vel_x      (vel_x),
        .vel_y      (vel_y),
        .vel_z      (vel_z),
        .target_x   (target_x),
        .target_y   (target_y),
        .target_alt (target_alt),
        .out_valid  (f_valid),
        .out_ready  (!q_full),
        .out_item   (f_item)
    );

    ssd_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_valid),
        .wr_item (f_item),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .q_empty (q_empty),
        .rd_item (q_item)
    );

    ssd_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .dist_sq      (dist_sq),
        .seg_fraction (seg_fraction)
    );

endmodule

### hdl/ssd_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Front stage
// Accepts an item, forms wrapped deltas and the segment start offset.
// ---------------------------------------------------------------------------
module ssd_front
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    push,
    output logic                                    full,
    input  logic [ssd_pkg::POS_BITS-1:0]            round_x,
    input  logic [ssd_pkg::POS_BITS-1:0]            round_y,
    input  logic signed [ssd_pkg::ALT_BITS-1:0]     round_alt,
    input  logic signed [ssd_pkg::VEL_BITS-1:0]     vel_x,
    input  logic signed [ssd_pkg::VEL_BITS-1:0]     vel_y,
    input  logic signed [ssd_pkg::VEL_BITS-1:0]     vel_z,
    input  logic [ssd_pkg::TGT_BITS-1:0]            target_x,
    input  logic [ssd_pkg::TGT_BITS-1:0]            target_y,
    input  logic signed [ssd_pkg::ALT_BITS-1:0]     target_alt,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output ssd_pkg::seg_item_t                      out_item
);

    logic [ssd_pkg::DIFFW-1:0]            dx_full;
    logic [ssd_pkg::DIFFW-1:0]            dy_full;
    logic signed [ssd_pkg::FINE_BITS-1:0] ax;
    logic signed [ssd_pkg::FINE_BITS-1:0] ay;
    ssd_pkg::seg_item_t                   item_next;
    ssd_pkg::seg_item_t                   item_reg;
    logic                                 valid_reg;
    logic                                 valid_next;
    logic                                 load;

    assign dx_full = ssd_pkg::DIFFW'(round_x)
                   - (ssd_pkg::DIFFW'(target_x) << ssd_pkg::COARSE_SHIFT);
    assign dy_full = ssd_pkg::DIFFW'(round_y)
                   - (ssd_pkg::DIFFW'(target_y) << ssd_pkg::COARSE_SHIFT);
    assign ax = $signed(dx_full[ssd_pkg::FINE_BITS-1:0]);
    assign ay = $signed(dy_full[ssd_pkg::FINE_BITS-1:0]);

    always_comb
    begin
        item_next.px = ssd_pkg::PW'(ax) - ssd_pkg::PW'(vel_x);
        item_next.py = ssd_pkg::PW'(ay) - ssd_pkg::PW'(vel_y);
        item_next.pz = ssd_pkg::ZW'(round_alt) - ssd_pkg::ZW'(target_alt)
                     - ssd_pkg::ZW'(vel_z);
        item_next.vx = vel_x;
        item_next.vy = vel_y;
        item_next.vz = vel_z;
        item_next.zero_seg = (vel_x == '0) && (vel_y == '0) && (vel_z == '0);
    end

    assign full       = valid_reg && !out_ready;
    assign load       = push && !full;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

### hdl/ssd_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Decoupling queue
// Two-entry register queue between the front and back stages.
// ---------------------------------------------------------------------------
module ssd_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  ssd_pkg::seg_item_t wr_item,
    output logic               q_full,
    input  logic               rd_en,
    output logic               q_empty,
    output ssd_pkg::seg_item_t rd_item
);

    ssd_pkg::seg_item_t slot_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         count_reg;
    logic [1:0]         count_next;
    logic               do_wr;
    logic               do_rd;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

### hdl/ssd_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Fraction divider
// Pipelined restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
module ssd_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  ssd_pkg::div_item_t in_item,
    output logic               out_valid,
    output ssd_pkg::div_item_t out_item
);

    ssd_pkg::div_item_t    st_reg  [ssd_pkg::QW];
    ssd_pkg::div_item_t    st_next [ssd_pkg::QW];
    logic [ssd_pkg::QW-1:0] vld_reg;

    function automatic ssd_pkg::div_item_t div_step(input ssd_pkg::div_item_t s);
        ssd_pkg::div_item_t   r;
        logic [ssd_pkg::REMW-1:0] shifted;
        r       = s;
        shifted = {s.rem[ssd_pkg::REMW-2:0], 1'b0};
        if (shifted >= {1'b0, s.seg2})
        begin
            r.rem = shifted - {1'b0, s.seg2};
            r.quo = {s.quo[ssd_pkg::QW-2:0], 1'b1};
        end
        else
        begin
            r.rem = shifted;
            r.quo = {s.quo[ssd_pkg::QW-2:0], 1'b0};
        end
        return r;
    endfunction

    always_comb
    begin
        st_next[0] = div_step(in_item);
        for (int k = 1; k < ssd_pkg::QW; k++)
        begin
            st_next[k] = div_step(st_reg[k-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[ssd_pkg::QW-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < ssd_pkg::QW; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign out_valid = vld_reg[ssd_pkg::QW-1];
    assign out_item  = st_reg[ssd_pkg::QW-1];

endmodule

### hdl/ssd_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Back pipeline
// Projects the target onto the segment and squares the closest offset.
// ---------------------------------------------------------------------------
module ssd_back
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_empty,
    input  ssd_pkg::seg_item_t               q_item,
    output logic                             q_pop,
    output logic                             empty,
    input  logic                             pop,
    output logic [ssd_pkg::DIST_BITS-1:0]    dist_sq,
    output logic [ssd_pkg::TW-1:0]           seg_fraction
);

    logic en;

    // Products of offset and velocity, and squared velocity components.
    logic                             v1_reg;
    ssd_pkg::seg_item_t               it1_reg;
    logic signed [ssd_pkg::PRODW-1:0] pvx_reg, pvy_reg, pvz_reg;
    logic [ssd_pkg::SEGW-1:0]         vvx_reg, vvy_reg, vvz_reg;

    // Dot product, squared segment length and clamp decision.
    logic signed [ssd_pkg::DOTW-1:0]  dot;
    logic [ssd_pkg::SEGW-1:0]         seg2;
    logic signed [ssd_pkg::DOTW-1:0]  seg2_s;
    ssd_pkg::div_item_t               d_next;
    logic                             v2_reg;
    ssd_pkg::div_item_t               d2_reg;

    logic                             vd;
    ssd_pkg::div_item_t               dd;
    logic [ssd_pkg::TW-1:0]           t_sel;

    logic                             v3_reg;
    ssd_pkg::seg_item_t               it3_reg;
    logic [ssd_pkg::TW-1:0]           t3_reg;
    logic signed [ssd_pkg::MW-1:0]    mx_reg, my_reg, mz_reg;

    logic signed [ssd_pkg::MW-1:0]    qx, qy, qz;
    logic                             v4_reg;
    logic [ssd_pkg::TW-1:0]           t4_reg;
    logic signed [ssd_pkg::CW-1:0]    cx_reg, cy_reg, cz_reg;

    logic                             v5_reg;
    logic [ssd_pkg::TW-1:0]           t5_reg;
    logic signed [ssd_pkg::SQW-1:0]   sx_reg, sy_reg, sz_reg;

    logic [ssd_pkg::SUMW-1:0]         sum;
    logic [ssd_pkg::EW-1:0]           sum_ext;
    logic                             v6_reg;
    ssd_pkg::res_item_t               r6_reg;

    ssd_pkg::res_item_t               ofifo_reg [2];
    logic                             owr_reg;
    logic                             ord_reg;
    logic [1:0]                       ocount_reg;
    logic [1:0]                       ocount_next;
    logic                             opush;
    logic                             opop;

    function automatic logic signed [ssd_pkg::MW-1:0] trunc_q8(
        input logic signed [ssd_pkg::MW-1:0] m);
        logic signed [ssd_pkg::MW-1:0] r;
        if (m < 0)
        begin
            r = (m + ssd_pkg::MW'(ssd_pkg::Q8_ONE - 1)) >>> 8;
        end
        else
        begin
            r = m >>> 8;
        end
        return r;
    endfunction

    assign en    = (ocount_reg != 2'd2);
    assign q_pop = en;

    always_comb
    begin
        dot    = -(ssd_pkg::DOTW'(pvx_reg) + ssd_pkg::DOTW'(pvy_reg)
                 + ssd_pkg::DOTW'(pvz_reg));
        seg2   = vvx_reg + vvy_reg + vvz_reg;
        seg2_s = $signed(ssd_pkg::DOTW'(seg2));
        d_next.item   = it1_reg;
        d_next.seg2   = seg2;
        d_next.rem    = dot[ssd_pkg::REMW-1:0];
        d_next.quo    = '0;
        d_next.bypass = 1'b1;
        d_next.t_fix  = '0;
        if (it1_reg.zero_seg || dot <= 0)
        begin
            d_next.t_fix = '0;
        end
        else if (dot >= seg2_s)
        begin
            d_next.t_fix = ssd_pkg::TW'(ssd_pkg::Q8_ONE);
        end
        else
        begin
            d_next.bypass = 1'b0;
        end
    end

    ssd_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2_reg),
        .in_item   (d2_reg),
        .out_valid (vd),
        .out_item  (dd)
    );

    assign t_sel = dd.bypass ? dd.t_fix : {1'b0, dd.quo};

    assign qx = trunc_q8(mx_reg);
    assign qy = trunc_q8(my_reg);
    assign qz = trunc_q8(mz_reg);

    assign sum = ssd_pkg::SUMW'($unsigned(sx_reg)) + ssd_pkg::SUMW'($unsigned(sy_reg))
               + ssd_pkg::SUMW'($unsigned(sz_reg));
    assign sum_ext = ssd_pkg::EW'(sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= !q_empty;
            v2_reg <= v1_reg;
            v3_reg <= vd;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            it1_reg <= q_item;
            pvx_reg <= ssd_pkg::PRODW'(q_item.px) * ssd_pkg::PRODW'(q_item.vx);
            pvy_reg <= ssd_pkg::PRODW'(q_item.py) * ssd_pkg::PRODW'(q_item.vy);
            pvz_reg <= ssd_pkg::PRODW'(q_item.pz) * ssd_pkg::PRODW'(q_item.vz);
            vvx_reg <= ssd_pkg::SEGW'(q_item.vx * q_item.vx);
            vvy_reg <= ssd_pkg::SEGW'(q_item.vy * q_item.vy);
            vvz_reg <= ssd_pkg::SEGW'(q_item.vz * q_item.vz);

            d2_reg <= d_next;

            it3_reg <= dd.item;
            t3_reg  <= t_sel;
            mx_reg  <= ssd_pkg::MW'(dd.item.vx) * ssd_pkg::MW'($signed({1'b0, t_sel}));
            my_reg  <= ssd_pkg::MW'(dd.item.vy) * ssd_pkg::MW'($signed({1'b0, t_sel}));
            mz_reg  <= ssd_pkg::MW'(dd.item.vz) * ssd_pkg::MW'($signed({1'b0, t_sel}));

            t4_reg <= t3_reg;
            cx_reg <= ssd_pkg::CW'(it3_reg.px) + ssd_pkg::CW'(qx);
            cy_reg <= ssd_pkg::CW'(it3_reg.py) + ssd_pkg::CW'(qy);
            cz_reg <= ssd_pkg::CW'(it3_reg.pz) + ssd_pkg::CW'(qz);

            t5_reg <= t4_reg;
            sx_reg <= ssd_pkg::SQW'(cx_reg) * ssd_pkg::SQW'(cx_reg);
            sy_reg <= ssd_pkg::SQW'(cy_reg) * ssd_pkg::SQW'(cy_reg);
            sz_reg <= ssd_pkg::SQW'(cz_reg) * ssd_pkg::SQW'(cz_reg);

            r6_reg.frac <= t5_reg;
            if (sum_ext > ssd_pkg::EW'(ssd_pkg::DIST_MAX))
            begin
                r6_reg.dsq <= ssd_pkg::DIST_MAX[ssd_pkg::DIST_BITS-1:0];
            end
            else
            begin
                r6_reg.dsq <= sum_ext[ssd_pkg::DIST_BITS-1:0];
            end
        end
    end

    assign opush = en && v6_reg;
    assign opop  = pop && (ocount_reg != 2'd0);

    always_comb
    begin
        ocount_next = ocount_reg;
        if (opush && !opop)
        begin
            ocount_next = ocount_reg + 2'd1;
        end
        else if (opop && !opush)
        begin
            ocount_next = ocount_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_reg    <= 1'b0;
            ord_reg    <= 1'b0;
            ocount_reg <= 2'd0;
        end
        else
        begin
            ocount_reg <= ocount_next;
            if (opush)
            begin
                owr_reg <= !owr_reg;
            end
            if (opop)
            begin
                ord_reg <= !ord_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (opush)
        begin
            ofifo_reg[owr_reg] <= r6_reg;
        end
    end

    assign empty        = (ocount_reg == 2'd0);
    assign dist_sq      = ofifo_reg[ord_reg].dsq;
    assign seg_fraction = ofifo_reg[ord_reg].frac;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ocount_reg != 2'd3)
        else $error("result buffer count out of range");

    a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> seg_fraction <= ssd_pkg::TW'(ssd_pkg::Q8_ONE))
        else $error("fraction above one");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v6_reg))
        else $error("pipeline moved while stalled");

    a_bypass_frac: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && d2_reg.item.zero_seg) |-> (d2_reg.bypass && d2_reg.t_fix == '0))
        else $error("zero-length segment not forced to start");

endmodule
